// ===== rtl/core/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes of the stack machine executor: opcodes, register
// selectors, result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int DEF_STACK_DEPTH = 256;

  localparam int DATA_W = 32;
  localparam int PC_W   = 16;
  localparam int OUT_SP_W = 9;
  localparam int NUM_GR = 6;

  // general register roles used by arithmetic
  localparam logic [2:0] GR_A = 3'd0;
  localparam logic [2:0] GR_B = 3'd1;
  localparam logic [2:0] GR_C = 3'd2;

  // MOV selectors beyond the general registers
  localparam logic [2:0] REG_PC = 3'd6;
  localparam logic [2:0] REG_SP = 3'd7;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_POP  = 4'd2;
  localparam logic [3:0] OP_RET  = 4'd4;
  localparam logic [3:0] OP_MUL  = 4'd5;
  localparam logic [3:0] OP_DIV  = 4'd6;
  localparam logic [3:0] OP_SUB  = 4'd7;
  localparam logic [3:0] OP_MOV  = 4'd8;
  localparam logic [3:0] OP_NOP  = 4'd9;

  // instruction lengths
  localparam logic [PC_W-1:0] LEN_ONE  = 16'd1;
  localparam logic [PC_W-1:0] LEN_PUSH = 16'd2;
  localparam logic [PC_W-1:0] LEN_MOV  = 16'd3;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_HALTED    = 3'd1,
    STS_UNDERFLOW = 3'd2,
    STS_OVERFLOW  = 3'd3,
    STS_DIV_ZERO  = 3'd4,
    STS_UNKNOWN   = 3'd5,
    STS_IGNORED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one decoded instruction per item on a 32-bit stack machine with a
// data stack in a synchronous memory, six general registers, a program
// counter and a stack pointer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid / in_stall | opcode, immediate, source/dest reg
//  out_    | output    | out_valid/out_stall | status, popped value, C, pc, sp
//
//  An item steps through IDLE (stack memory read of the top two entries),
//  EXEC (execute and write back) and DONE (load the output register); no
//  new item is taken before IDLE. DIV adds S_DIV for the bit-serial divider
//  (one quotient bit a cycle) and S_DIVFIN for its final write back.
//  rst_n is synchronous; it empties the stack, clears registers and halt.
//  A result waiting under out_stall does not block the next item; the
//  following result holds in the core until the output register frees up.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [3:0]                              in_opcode,
  input  logic signed [smx_pkg::DATA_W-1:0]       in_immediate,
  input  logic [2:0]                              in_source_register,
  input  logic [2:0]                              in_dest_register,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [2:0]                              out_status,
  output logic                                    out_popped_valid,
  output logic signed [smx_pkg::DATA_W-1:0]       out_popped_value,
  output logic signed [smx_pkg::DATA_W-1:0]       out_arith_value,
  output logic [smx_pkg::PC_W-1:0]                out_program_counter,
  output logic signed [smx_pkg::OUT_SP_W-1:0]     out_stack_pointer
);
  import smx_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = AW + 1;
  localparam logic signed [SP_W-1:0]   SP_MAX   = SP_W'(STACK_DEPTH - 1);
  localparam logic signed [SP_W-1:0]   SP_EMPTY = '1;
  localparam logic signed [DATA_W-1:0] SP_MAX32 = DATA_W'(STACK_DEPTH - 1);
  localparam logic signed [DATA_W-1:0] MINUS1   = -32'sd1;

  // stack memory
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_top_r, rd_next_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  // architectural state
  state_t                   state_r, state_nxt;
  logic signed [SP_W-1:0]   sp_r, sp_nxt;
  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic                     halt_r, halt_nxt;
  logic [DATA_W-1:0]        gr_r   [NUM_GR];
  logic [DATA_W-1:0]        gr_nxt [NUM_GR];

  // latched item
  logic [3:0]        op_r;
  logic [DATA_W-1:0] imm_r;
  logic [2:0]        src_r, dst_r;

  // step result waiting for the output register
  status_t           sts_r, sts_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic [DATA_W-1:0] pval_r, pval_nxt;

  // divider
  logic [DATA_W-1:0] div_rem_r, div_quo_r, div_den_r;
  logic [4:0]        div_cnt_r;
  logic              div_neg_r;
  logic              div_start;
  logic [DATA_W:0]   div_rem_sh;
  logic              div_fit;
  logic [DATA_W-1:0] div_quot;

  // output register
  logic              out_valid_r;
  logic              load_out;
  logic [2:0]        out_status_r;
  logic              out_pvalid_r;
  logic [DATA_W-1:0] out_pval_r, out_arith_r;
  logic [PC_W-1:0]   out_pc_r;
  logic [OUT_SP_W-1:0] out_sp_r;

  logic                    accept;
  logic signed [SP_W-1:0]  sp_inc, sp_dec;
  logic [DATA_W-1:0]       sp_ext;
  logic [DATA_W-1:0]       arith_c;
  logic [DATA_W-1:0]       mul_res;
  logic [DATA_W-1:0]       mov_v;
  logic signed [DATA_W-1:0] mov_sv;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign sp_inc = sp_r + SP_W'(1);
  assign sp_dec = sp_r - SP_W'(1);
  assign sp_ext = {{(DATA_W-SP_W){sp_r[SP_W-1]}}, sp_r};

  // ---------------- stack memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_top_r  <= stack_mem[sp_r[AW-1:0]];
    rd_next_r <= stack_mem[sp_dec[AW-1:0]];
  end

  // ---------------- divider datapath ----------------
  assign div_rem_sh = {div_rem_r, div_quo_r[DATA_W-1]};
  assign div_fit    = (div_rem_sh >= {1'b0, div_den_r});
  assign div_quot   = div_neg_r ? (DATA_W'(0) - div_quo_r) : div_quo_r;

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem_r <= '0;
      div_quo_r <= rd_next_r[DATA_W-1] ? (DATA_W'(0) - rd_next_r) : rd_next_r;
      div_den_r <= rd_top_r[DATA_W-1] ? (DATA_W'(0) - rd_top_r) : rd_top_r;
      div_neg_r <= rd_next_r[DATA_W-1] ^ rd_top_r[DATA_W-1];
      div_cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      div_rem_r <= div_fit ? DATA_W'(div_rem_sh - {1'b0, div_den_r})
                           : div_rem_sh[DATA_W-1:0];
      div_quo_r <= {div_quo_r[DATA_W-2:0], div_fit};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // ---------------- arithmetic ----------------
  assign mul_res = DATA_W'(rd_next_r * rd_top_r);

  always_comb begin
    case (op_r)
      OP_ADD:  arith_c = rd_top_r + rd_next_r;
      OP_SUB:  arith_c = rd_next_r - rd_top_r;
      OP_MUL:  arith_c = mul_res;
      default: arith_c = div_quot;
    endcase
  end

  always_comb begin
    if (src_r == REG_PC) begin
      mov_v = {{(DATA_W-PC_W){1'b0}}, pc_r};
    end else if (src_r == REG_SP) begin
      mov_v = sp_ext;
    end else begin
      mov_v = gr_r[src_r];
    end
  end
  assign mov_sv = mov_v;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = div_start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_cnt_r == 5'd31) state_nxt = S_DIVFIN;
      end
      S_DIVFIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- execute and write back ----------------
  always_comb begin
    sp_nxt     = sp_r;
    pc_nxt     = pc_r;
    halt_nxt   = halt_r;
    gr_nxt     = gr_r;
    sts_nxt    = sts_r;
    pvalid_nxt = pvalid_r;
    pval_nxt   = pval_r;
    mem_we     = 1'b0;
    mem_wa     = sp_dec[AW-1:0];
    mem_wd     = arith_c;
    div_start  = 1'b0;

    case (state_r)
      S_DIVFIN: begin
        gr_nxt[GR_A] = rd_top_r;
        gr_nxt[GR_B] = rd_next_r;
        gr_nxt[GR_C] = arith_c;
        sp_nxt       = sp_dec;
        mem_we       = 1'b1;
        pc_nxt       = pc_r + LEN_ONE;
      end
      S_EXEC: begin
        sts_nxt    = STS_OK;
        pvalid_nxt = 1'b0;
        pval_nxt   = '0;
        if (halt_r) begin
          sts_nxt = STS_IGNORED;
        end else begin
          case (op_r)
            OP_PUSH: begin
              if (sp_r >= SP_MAX) begin
                sts_nxt = STS_OVERFLOW;
              end else begin
                sp_nxt = sp_inc;
                mem_we = 1'b1;
                mem_wa = sp_inc[AW-1:0];
                mem_wd = imm_r;
                pc_nxt = pc_r + LEN_PUSH;
              end
            end
            OP_POP: begin
              if (sp_r < 0) begin
                sts_nxt = STS_UNDERFLOW;
              end else begin
                pvalid_nxt = 1'b1;
                pval_nxt   = rd_top_r;
                sp_nxt     = sp_dec;
                pc_nxt     = pc_r + LEN_ONE;
              end
            end
            OP_RET: begin
              halt_nxt = 1'b1;
              sts_nxt  = STS_HALTED;
              pc_nxt   = pc_r + LEN_ONE;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp_r < SP_W'(1)) begin
                sts_nxt = STS_UNDERFLOW;
              end else if (op_r == OP_DIV && rd_top_r == '0) begin
                sts_nxt = STS_DIV_ZERO;
              end else if (op_r == OP_DIV) begin
                div_start = 1'b1;
              end else begin
                gr_nxt[GR_A] = rd_top_r;
                gr_nxt[GR_B] = rd_next_r;
                gr_nxt[GR_C] = arith_c;
                sp_nxt       = sp_dec;
                mem_we       = 1'b1;
                pc_nxt       = pc_r + LEN_ONE;
              end
            end
            OP_MOV: begin
              if (dst_r == REG_PC) begin
                pc_nxt = mov_v[PC_W-1:0] + LEN_MOV;
              end else if (dst_r == REG_SP) begin
                if (mov_sv < MINUS1) begin
                  sts_nxt = STS_UNDERFLOW;
                end else if (mov_sv > SP_MAX32) begin
                  sts_nxt = STS_OVERFLOW;
                end else begin
                  sp_nxt = mov_sv[SP_W-1:0];
                  pc_nxt = pc_r + LEN_MOV;
                end
              end else begin
                gr_nxt[dst_r] = mov_v;
                pc_nxt        = pc_r + LEN_MOV;
              end
            end
            OP_NOP: begin
              pc_nxt = pc_r + LEN_ONE;
            end
            default: begin
              sts_nxt = STS_UNKNOWN;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= SP_EMPTY;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_GR; i++) begin
        gr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      gr_r    <= gr_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      imm_r <= in_immediate;
      src_r <= in_source_register;
      dst_r <= in_dest_register;
    end
    sts_r    <= sts_nxt;
    pvalid_r <= pvalid_nxt;
    pval_r   <= pval_nxt;
    if (load_out) begin
      out_status_r <= sts_r;
      out_pvalid_r <= pvalid_r;
      out_pval_r   <= pval_r;
      out_arith_r  <= gr_r[GR_C];
      out_pc_r     <= pc_r;
      out_sp_r     <= sp_ext[OUT_SP_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_popped_valid    = out_pvalid_r;
  assign out_popped_value    = out_pval_r;
  assign out_arith_value     = out_arith_r;
  assign out_program_counter = out_pc_r;
  assign out_stack_pointer   = out_sp_r;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stack machine executor testbench
// Drives decoded instructions into the executor and checks every result
// against an in-bench machine model kept at the port widths. Directed items
// hit the arithmetic and stack corners and the register moves, then the stack
// is filled to overflow and drained. A receiver hold-off backs up the block.
// A long random program follows, and the run closes with a halt.
// ----------------------------------------------------------------------------
module tb;
  import smx_pkg::*;

  localparam int DEPTH          = DEF_STACK_DEPTH;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_REPORTS    = 200;
  localparam int RUN_LIMIT      = 20_000_000;

  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [3:0]        OP_RSVD  = 4'd3;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    status_t               status;
    logic                  popped_valid;
    logic [DATA_W-1:0]     popped_value;
    logic [DATA_W-1:0]     reg_c;
    logic [PC_W-1:0]       pc;
    logic [OUT_SP_W-1:0]   sp;
  } exec_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [3:0]                 in_opcode = OP_NOP;
  logic signed [DATA_W-1:0]   in_immediate = '0;
  logic [2:0]                 in_source_register = GR_A;
  logic [2:0]                 in_dest_register = GR_A;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [2:0]                 out_status;
  logic                       out_popped_valid;
  logic signed [DATA_W-1:0]   out_popped_value;
  logic signed [DATA_W-1:0]   out_arith_value;
  logic [PC_W-1:0]            out_program_counter;
  logic signed [OUT_SP_W-1:0] out_stack_pointer;

  // machine state as the model sees it
  logic [DATA_W-1:0] stack_mem [DEPTH];
  bit                stack_written [DEPTH];
  int                top_idx = -1;
  logic [DATA_W-1:0] gregs [NUM_GR] = '{default: '0};
  logic [PC_W-1:0]   pc_val = '0;
  bit                halted_flag = 1'b0;

  exec_result_t pending_results[$];
  int           mismatch_count = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  bit           rx_hold_req = 1'b0;

  stack_machine_executor i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_immediate        (in_immediate),
    .in_source_register  (in_source_register),
    .in_dest_register    (in_dest_register),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_popped_valid    (out_popped_valid),
    .out_popped_value    (out_popped_value),
    .out_arith_value     (out_arith_value),
    .out_program_counter (out_program_counter),
    .out_stack_pointer   (out_stack_pointer)
  );

  always #10 clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Machine model: execute one accepted instruction, queue its result
  // --------------------------------------------------------------------------
  task automatic execute_instr(input logic [3:0] op, input logic [DATA_W-1:0] imm,
                               input logic [2:0] src, input logic [2:0] dst);
    exec_result_t      r;
    logic [DATA_W-1:0] opa, opb, res, mv;
    longint            num, den;
    r.status       = STS_OK;
    r.popped_valid = 1'b0;
    r.popped_value = '0;
    if (halted_flag) begin
      r.status = STS_IGNORED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (top_idx >= DEPTH - 1) begin
            r.status = STS_OVERFLOW;
          end else begin
            top_idx++;
            stack_mem[top_idx] = imm;
            stack_written[top_idx] = 1'b1;
            pc_val += LEN_PUSH;
          end
        end
        OP_POP: begin
          if (top_idx < 0) begin
            r.status = STS_UNDERFLOW;
          end else begin
            r.popped_valid = 1'b1;
            r.popped_value = stack_mem[top_idx];
            top_idx--;
            pc_val += LEN_ONE;
          end
        end
        OP_RET: begin
          halted_flag = 1'b1;
          r.status = STS_HALTED;
          pc_val += LEN_ONE;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (top_idx < 1) begin
            r.status = STS_UNDERFLOW;
          end else begin
            opa = stack_mem[top_idx];
            opb = stack_mem[top_idx - 1];
            if (op == OP_DIV && opa == '0) begin
              r.status = STS_DIV_ZERO;
            end else begin
              case (op)
                OP_ADD: res = opb + opa;
                OP_SUB: res = opb - opa;
                OP_MUL: res = opb * opa;
                default: begin
                  // divide in 64 bits so the most negative over -1 just wraps
                  num = $signed(opb);
                  den = $signed(opa);
                  res = 32'(num / den);
                end
              endcase
              gregs[GR_A] = opa;
              gregs[GR_B] = opb;
              gregs[GR_C] = res;
              top_idx--;
              stack_mem[top_idx] = res;
              stack_written[top_idx] = 1'b1;
              pc_val += LEN_ONE;
            end
          end
        end
        OP_MOV: begin
          if (src < NUM_GR) mv = gregs[src];
          else if (src == REG_PC) mv = {16'b0, pc_val};
          else mv = 32'(top_idx);
          if (dst < NUM_GR) begin
            gregs[dst] = mv;
            pc_val += LEN_MOV;
          end else if (dst == REG_PC) begin
            pc_val = mv[PC_W-1:0] + LEN_MOV;
          end else if ($signed(mv) < -1) begin
            r.status = STS_UNDERFLOW;
          end else if ($signed(mv) > DEPTH - 1) begin
            r.status = STS_OVERFLOW;
          end else begin
            top_idx = $signed(mv);
            pc_val += LEN_MOV;
          end
        end
        OP_NOP: pc_val += LEN_ONE;
        default: r.status = STS_UNKNOWN;
      endcase
    end
    r.reg_c = gregs[GR_C];
    r.pc    = pc_val;
    r.sp    = 9'(top_idx);
    pending_results.push_back(r);
  endtask

  // Never read a stack entry that was not written: turn such a read into a push.
  function automatic logic [3:0] legal_op(input logic [3:0] op);
    if (halted_flag) return op;
    if (op == OP_POP && top_idx >= 0 && !stack_written[top_idx]) return OP_PUSH;
    if ((op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) && top_idx >= 1 &&
        !(stack_written[top_idx] && stack_written[top_idx - 1])) return OP_PUSH;
    return op;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
      1: return '0;
      2: return $urandom_range(0, 1) ? '1 : 32'd1;
      3, 4: return $urandom_range(0, 300);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_arith();
    case ($urandom_range(0, 3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  function automatic logic [3:0] pick_opcode();
    int         roll;
    logic [3:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 28 || (top_idx < 1 && roll < 45)) begin
      op = OP_PUSH;
    end else if (roll < 38) begin
      op = OP_POP;
    end else if (roll < 62) begin
      op = pick_arith();
    end else if (roll < 80) begin
      op = OP_MOV;
    end else if (roll < 87) begin
      op = OP_NOP;
    end else if (roll < 93) begin
      do op = 4'($urandom_range(0, 15));
      while (op inside {OP_PUSH, OP_ADD, OP_POP, OP_RET, OP_MUL, OP_DIV, OP_SUB,
                        OP_MOV, OP_NOP});
    end else begin
      // noise; hold the halt back for the end of the run
      op = 4'($urandom_range(0, 15));
      if (op == OP_RET) op = OP_NOP;
    end
    return op;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call, bursts with random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_instr(input logic [3:0] op, input logic [DATA_W-1:0] imm,
                            input logic [2:0] src, input logic [2:0] dst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_immediate       <= imm;
    in_source_register <= src;
    in_dest_register   <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    execute_instr(op, imm, src, dst);
  endtask

  task automatic send_random();
    logic [3:0] op;
    op = legal_op(pick_opcode());
    send_instr(op, pick_value(), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches among random modes; hold on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    int       phase_cnt;
    rx_mode   = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    phase_cnt = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        phase_cnt++;
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= (phase_cnt % 7) < 3;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest queued expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      // keep the log short on a badly broken block
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    exec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result with nothing pending, status %0h", $time, out_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("popped_valid", want.popped_valid, out_popped_valid);
        check_field("popped_value", want.popped_value, out_popped_value);
        check_field("arith_value", want.reg_c, out_arith_value);
        check_field("program_counter", want.pc, out_program_counter);
        check_field("stack_pointer", want.sp, out_stack_pointer[OUT_SP_W-1:0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_arith_corners();
    send_instr(OP_POP,  '0,       GR_A, GR_A);    // pop of an empty stack
    send_instr(OP_PUSH, WORD_MIN, GR_A, GR_A);
    send_instr(OP_DIV,  '0,       GR_A, GR_A);    // only one operand
    send_instr(OP_PUSH, '1,       REG_SP, REG_SP);
    send_instr(OP_DIV,  '0,       GR_A, GR_A);    // most negative over -1
    send_instr(OP_PUSH, '0,       GR_A, GR_A);
    send_instr(OP_DIV,  '0,       GR_A, GR_A);    // divide by zero
    send_instr(OP_MUL,  '0,       GR_A, GR_A);
    send_instr(OP_PUSH, WORD_MAX, GR_A, GR_A);
    send_instr(OP_SUB,  '0,       GR_A, GR_A);    // leaves C far below -1
  endtask

  task automatic test_register_moves();
    send_instr(OP_MOV,  '0,     GR_C,   REG_SP);  // stack pointer source too low
    send_instr(OP_POP,  '0,     GR_A,   GR_A);
    send_instr(OP_MOV,  '0,     REG_SP, GR_A);    // empty stack reads as -1
    send_instr(OP_MOV,  '0,     GR_A,   REG_SP);
    send_instr(OP_PUSH, 32'd255, GR_A,  GR_A);
    send_instr(OP_PUSH, '0,     GR_A,   GR_A);
    send_instr(OP_ADD,  '0,     GR_A,   GR_A);
    send_instr(OP_MOV,  '0,     GR_C,   REG_SP);  // jump to the last entry
    send_instr(OP_PUSH, 32'd1,  GR_A,   GR_A);    // full stack
    send_instr(OP_MOV,  '0,     GR_A,   REG_SP);
    send_instr(OP_PUSH, 32'd1,  GR_A,   GR_A);
    send_instr(OP_ADD,  '0,     GR_A,   GR_A);
    send_instr(OP_MOV,  '0,     GR_C,   REG_SP);  // one past the last entry
    send_instr(OP_MOV,  '0,     GR_C,   REG_PC);
    send_instr(OP_NOP,  '0,     GR_A,   GR_A);
    send_instr(OP_RSVD, '1,     REG_SP, REG_SP);
  endtask

  task automatic test_fill_and_drain();
    while (top_idx < DEPTH - 1)
      send_instr(OP_PUSH, pick_value(), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    send_instr(OP_PUSH, pick_value(), GR_A, GR_A);
    while (top_idx >= 0)
      send_instr(legal_op($urandom_range(0, 1) ? OP_POP : pick_arith()), '0,
                 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    send_instr(OP_POP, '0, GR_A, GR_A);
  endtask

  task automatic test_backpressure();
    // hold the receiver and keep offering items back to back
    gaps_on = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) send_random();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_program();
    repeat (RANDOM_ITEMS) send_random();
  endtask

  task automatic test_halt();
    send_instr(OP_RET, '0, GR_A, GR_A);
    repeat (10)
      send_instr(4'($urandom_range(0, 15)), pick_value(), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_arith_corners();
    test_register_moves();
    test_fill_and_drain();
    test_backpressure();
    test_random_program();
    test_halt();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/smx_pkg.sv
rtl/core/stack_machine_executor.sv
dv/tb.sv
